>>> src/h2r_pkg.sv
package h2r_pkg;

	// One HSV input item.
	typedef struct packed {
		logic [12:0] hue_sixteenths;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_item_t;

	// One RGB result item.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_item_t;

	// Hue geometry in sixteenths of a degree.
	localparam int unsigned SECTOR_UNITS  = 960;
	localparam int unsigned DOUBLE_SECTOR = 1920;
	localparam int unsigned FULL_SCALE    = 255;
	localparam int unsigned X_DENOM       = 244800;

	// Rounding divisors (twice the denominators) and their reciprocals.
	localparam int unsigned Z_DIV   = 2 * FULL_SCALE;
	localparam int unsigned Z_SHIFT = 17;
	localparam int unsigned Z_RECIP = (1 << Z_SHIFT) / Z_DIV;
	localparam int unsigned X_DIV   = 2 * X_DENOM;
	localparam int unsigned X_SHIFT = 27;
	localparam int unsigned X_RECIP = (1 << X_SHIFT) / X_DIV;

	// Sector codes, named by the hues they span.
	localparam logic [2:0] SECT_RED_YEL = 3'd0;
	localparam logic [2:0] SECT_YEL_GRN = 3'd1;
	localparam logic [2:0] SECT_GRN_CYN = 3'd2;
	localparam logic [2:0] SECT_CYN_BLU = 3'd3;
	localparam logic [2:0] SECT_BLU_MAG = 3'd4;
	localparam logic [2:0] SECT_MAG_RED = 3'd5;

endpackage

>>> src/h2r_hue_split.sv
module h2r_hue_split (
	input  logic [12:0] hue,
	output logic [2:0]  sector,
	output logic [9:0]  frac
);

	logic [10:0] phase;

	// Sector by comparison against the sector boundaries; hues past the
	// full circle stay in the last sector.
	always_comb begin
		priority if (hue < 13'(h2r_pkg::SECTOR_UNITS)) begin
			sector = h2r_pkg::SECT_RED_YEL;
		end else if (hue < 13'(2 * h2r_pkg::SECTOR_UNITS)) begin
			sector = h2r_pkg::SECT_YEL_GRN;
		end else if (hue < 13'(3 * h2r_pkg::SECTOR_UNITS)) begin
			sector = h2r_pkg::SECT_GRN_CYN;
		end else if (hue < 13'(4 * h2r_pkg::SECTOR_UNITS)) begin
			sector = h2r_pkg::SECT_CYN_BLU;
		end else if (hue < 13'(5 * h2r_pkg::SECTOR_UNITS)) begin
			sector = h2r_pkg::SECT_BLU_MAG;
		end else begin
			sector = h2r_pkg::SECT_MAG_RED;
		end
	end

	// Hue modulo two sectors, by one selected subtraction.
	always_comb begin
		logic [12:0] diff;
		priority if (hue >= 13'(4 * h2r_pkg::DOUBLE_SECTOR)) begin
			diff = hue - 13'(4 * h2r_pkg::DOUBLE_SECTOR);
		end else if (hue >= 13'(3 * h2r_pkg::DOUBLE_SECTOR)) begin
			diff = hue - 13'(3 * h2r_pkg::DOUBLE_SECTOR);
		end else if (hue >= 13'(2 * h2r_pkg::DOUBLE_SECTOR)) begin
			diff = hue - 13'(2 * h2r_pkg::DOUBLE_SECTOR);
		end else if (hue >= 13'(h2r_pkg::DOUBLE_SECTOR)) begin
			diff = hue - 13'(h2r_pkg::DOUBLE_SECTOR);
		end else begin
			diff = hue;
		end
		phase = diff[10:0];
	end

	// Distance of the phase from the sector edge, a triangle from 0 to 960.
	always_comb begin
		logic [10:0] mirror;
		mirror = 11'(h2r_pkg::DOUBLE_SECTOR) - phase;
		if (phase >= 11'(h2r_pkg::SECTOR_UNITS)) begin
			frac = mirror[9:0];
		end else begin
			frac = phase[9:0];
		end
	end

endmodule

>>> src/hsv_to_rgb_core.sv
// HSV to RGB color converter for a pixel stream.
//
// Input channel hsv_valid / hsv_stall / hsv carries one HSV item: hue in
// sixteenths of a degree, saturation and brightness as 8-bit fractions of one.
// Output channel rgb_valid / rgb_stall / rgb carries one RGB item per input
// item, in order. An item moves on a rising edge where valid is high and
// stall is low.
//
// Throughput is one item per clock while the receiver does not stall. The work
// runs through five register stages (hue split, two multiply stages, two
// reciprocal-divide stages with remainder correction); the result shows on
// rgb straight from the last stage register.
//
// Each stage holds an item until the next stage can take it. A stall from
// the receiver backs up stage by stage, so hsv_stall rises only once every
// stage holds an item; bubbles keep being filled meanwhile. Nothing is lost
// or repeated. Reset clears all valid bits; the data registers are not reset.
module hsv_to_rgb_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hsv_valid,
	output logic                hsv_stall,
	input  h2r_pkg::hsv_item_t  hsv,
	output logic                rgb_valid,
	input  logic                rgb_stall,
	output h2r_pkg::rgb_item_t  rgb
);

	// Stage valid bits and advance enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// Stage 1: hue split.
	logic [2:0]  sector_s1;
	logic [9:0]  frac_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1;
	logic [2:0]  sector_c;
	logic [9:0]  frac_c;

	// Stage 2: products.
	logic [2:0]  sector_s2;
	logic [7:0]  val_s2;
	logic [16:0] znum_s2;
	logic [17:0] inner_s2;

	// Stage 3: numerators and first zero-channel quotient.
	logic [2:0]  sector_s3;
	logic [7:0]  val_s3;
	logic [16:0] znum_s3;
	logic [7:0]  zq_s3;
	logic [26:0] xnum_s3;

	// Stage 4: zero channel done, first x quotient.
	logic [2:0]  sector_s4;
	logic [7:0]  val_s4;
	logic [7:0]  zc_s4;
	logic [26:0] xnum_s4;
	logic [7:0]  xq_s4;

	// Stage 5 is the output register.
	h2r_pkg::rgb_item_t rgb_s5;

	// Backpressure: a stage may load when it is empty or its item moves on.
	assign en_s5     = !valid_s5 || !rgb_stall;
	assign en_s4     = !valid_s4 || en_s5;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign hsv_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= hsv_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	h2r_hue_split u_hue_split (
		.hue    (hsv.hue_sixteenths),
		.sector (sector_c),
		.frac   (frac_c)
	);

	// Stage 1 register.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			sector_s1 <= sector_c;
			frac_s1   <= frac_c;
			sat_s1    <= hsv.saturation;
			val_s1    <= hsv.brightness;
		end
	end

	// Stage 2: V*(255-S) and 960*(255-S) + S*F.
	always_ff @(posedge clk) begin
		logic [7:0]  invs;
		logic [15:0] pz;
		logic [17:0] pa;
		logic [17:0] pb;
		if (en_s2) begin
			invs      = 8'(h2r_pkg::FULL_SCALE) - sat_s1;
			pz        = val_s1 * invs;
			pa        = {10'd0, invs} * 18'(h2r_pkg::SECTOR_UNITS);
			pb        = {10'd0, sat_s1} * {8'd0, frac_s1};
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			znum_s2   <= {pz, 1'b0} + 17'(h2r_pkg::FULL_SCALE);
			inner_s2  <= pa + pb;
		end
	end

	// Stage 3: x numerator and reciprocal estimate of the zero channel.
	always_ff @(posedge clk) begin
		logic [25:0] m;
		logic [25:0] zp;
		if (en_s3) begin
			m         = {18'd0, val_s2} * {8'd0, inner_s2};
			zp        = {9'd0, znum_s2} * 26'(h2r_pkg::Z_RECIP);
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			znum_s3   <= znum_s2;
			zq_s3     <= zp[h2r_pkg::Z_SHIFT +: 8];
			xnum_s3   <= {m, 1'b0} + 27'(h2r_pkg::X_DENOM);
		end
	end

	// Stage 4: correct the zero channel, estimate the x channel.
	always_ff @(posedge clk) begin
		logic [16:0] zrem;
		logic [8:0]  zinc;
		logic [35:0] xp;
		if (en_s4) begin
			zrem      = znum_s3 - ({9'd0, zq_s3} * 17'(h2r_pkg::Z_DIV));
			zinc      = {1'b0, zq_s3} + 9'd1;
			xp        = {9'd0, xnum_s3} * 36'(h2r_pkg::X_RECIP);
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			zc_s4     <= (zrem >= 17'(h2r_pkg::Z_DIV)) ? zinc[7:0] : zq_s3;
			xnum_s4   <= xnum_s3;
			xq_s4     <= xp[h2r_pkg::X_SHIFT +: 8];
		end
	end

	// Stage 5: correct the x channel and place channels by sector.
	always_ff @(posedge clk) begin
		logic [26:0] xrem;
		logic [8:0]  xinc;
		logic [7:0]  xc;
		if (en_s5) begin
			xrem = xnum_s4 - ({19'd0, xq_s4} * 27'(h2r_pkg::X_DIV));
			xinc = {1'b0, xq_s4} + 9'd1;
			xc   = (xrem >= 27'(h2r_pkg::X_DIV)) ? xinc[7:0] : xq_s4;
			unique case (sector_s4)
				h2r_pkg::SECT_RED_YEL: rgb_s5 <= '{red: val_s4, green: xc, blue: zc_s4};
				h2r_pkg::SECT_YEL_GRN: rgb_s5 <= '{red: xc, green: val_s4, blue: zc_s4};
				h2r_pkg::SECT_GRN_CYN: rgb_s5 <= '{red: zc_s4, green: val_s4, blue: xc};
				h2r_pkg::SECT_CYN_BLU: rgb_s5 <= '{red: zc_s4, green: xc, blue: val_s4};
				h2r_pkg::SECT_BLU_MAG: rgb_s5 <= '{red: xc, green: zc_s4, blue: val_s4};
				h2r_pkg::SECT_MAG_RED: rgb_s5 <= '{red: val_s4, green: zc_s4, blue: xc};
				default:               rgb_s5 <= '{red: val_s4, green: zc_s4, blue: xc};
			endcase
		end
	end

	assign rgb_valid = valid_s5;
	assign rgb       = rgb_s5;

`ifndef SYNTHESIS
	// An empty first stage always takes a new item.
	a_bubble_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !hsv_stall)
		else $error("input stalled with an empty first stage");

	// The input stalls only when every stage holds an item.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5
			&& rgb_stall))
		else $error("input stalled while the pipeline had room");

	// An accepted item lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_stall |=> valid_s1)
		else $error("accepted item lost at the first stage");

	// A taken result with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_stall && !valid_s4 |=> !rgb_valid)
		else $error("result repeated after it was taken");

	// The sector code never goes past the last sector.
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> sector_s1 <= h2r_pkg::SECT_MAG_RED)
		else $error("sector code out of range");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned RANDOM_ITEMS = 1450;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned DRAIN_CYCLES = 20;

	// The receiver holds off once for a long stretch after this many results.
	localparam int unsigned HOLD_AFTER   = 400;
	localparam int unsigned HOLD_CYCLES  = 250;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                hsv_valid = 1'b0;
	logic                hsv_stall;
	h2r_pkg::hsv_item_t  hsv = '0;
	logic                rgb_valid;
	logic                rgb_stall = 1'b0;
	h2r_pkg::rgb_item_t  rgb;

	h2r_pkg::hsv_item_t  pending_hsv[$];
	h2r_pkg::rgb_item_t  expected_rgb[$];
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned total_items = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned hsv_gap = 0;
	int unsigned rgb_wait = 0;
	int unsigned rgb_wait_next;
	int unsigned hold_cycles = 0;
	logic        hold_used = 1'b0;

	hsv_to_rgb_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Exact HSV to RGB conversion: chroma is the brightness, intermediate and
	// zero channels rounded half up, all placed by the 60-degree sector of the hue.
	function automatic h2r_pkg::rgb_item_t predict_rgb(input h2r_pkg::hsv_item_t px);
		int unsigned sector_idx;
		int unsigned phase;
		int unsigned frac;
		longint unsigned sat;
		longint unsigned val;
		longint unsigned z_num;
		longint unsigned x_num;
		logic [7:0] c_ch;
		logic [7:0] x_ch;
		logic [7:0] z_ch;
		h2r_pkg::rgb_item_t res;
		sector_idx = px.hue_sixteenths / h2r_pkg::SECTOR_UNITS;
		// Hues at or beyond a full turn stay in the last sector.
		if (sector_idx > h2r_pkg::SECT_MAG_RED)
			sector_idx = h2r_pkg::SECT_MAG_RED;
		phase = px.hue_sixteenths % h2r_pkg::DOUBLE_SECTOR;
		frac = (phase >= h2r_pkg::SECTOR_UNITS) ? (h2r_pkg::DOUBLE_SECTOR - phase) : phase;
		sat = px.saturation;
		val = px.brightness;
		z_num = val * (h2r_pkg::FULL_SCALE - sat);
		x_num = val * (h2r_pkg::SECTOR_UNITS * (h2r_pkg::FULL_SCALE - sat) + sat * frac);
		c_ch = px.brightness;
		z_ch = 8'((2 * z_num + h2r_pkg::FULL_SCALE) / (2 * h2r_pkg::FULL_SCALE));
		x_ch = 8'((2 * x_num + h2r_pkg::X_DENOM) / (2 * h2r_pkg::X_DENOM));
		case (sector_idx)
			h2r_pkg::SECT_RED_YEL: begin
				res.red = c_ch; res.green = x_ch; res.blue = z_ch;
			end
			h2r_pkg::SECT_YEL_GRN: begin
				res.red = x_ch; res.green = c_ch; res.blue = z_ch;
			end
			h2r_pkg::SECT_GRN_CYN: begin
				res.red = z_ch; res.green = c_ch; res.blue = x_ch;
			end
			h2r_pkg::SECT_CYN_BLU: begin
				res.red = z_ch; res.green = x_ch; res.blue = c_ch;
			end
			h2r_pkg::SECT_BLU_MAG: begin
				res.red = x_ch; res.green = z_ch; res.blue = c_ch;
			end
			default: begin
				res.red = c_ch; res.green = z_ch; res.blue = x_ch;
			end
		endcase
		return res;
	endfunction

	// Idle cycles before the next item; some stretches run with no idling.
	function automatic int unsigned draw_wait(input int unsigned idx);
		if (idx % 300 < 60)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	// A byte that favors the extremes now and then.
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 2));
			3: return 8'($urandom_range(253, 254));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Hue spread over normal range, sector edges and the out-of-range codes.
	function automatic logic [12:0] rand_hue();
		int unsigned edge_hue;
		case ($urandom_range(0, 9))
			0: begin
				edge_hue = $urandom_range(0, 8) * h2r_pkg::SECTOR_UNITS
					+ $urandom_range(0, 2);
				return 13'(edge_hue > 0 ? edge_hue - 1 : 0);
			end
			1, 2: return 13'($urandom_range(5760, 8191));
			default: return 13'($urandom_range(0, 5759));
		endcase
	endfunction

	task automatic add_hsv(input int unsigned hue, input int unsigned sat,
			input int unsigned val);
		h2r_pkg::hsv_item_t px;
		px.hue_sixteenths = 13'(hue);
		px.saturation = 8'(sat);
		px.brightness = 8'(val);
		pending_hsv.push_back(px);
	endtask

	// Sender: offers the next item after its drawn idle gap and records the
	// expected color of every item that the block takes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
			hsv <= '0;
			hsv_gap <= 0;
			items_sent <= 0;
		end else begin
			if (hsv_valid && !hsv_stall) begin
				expected_rgb.push_back(predict_rgb(hsv));
				items_sent <= items_sent + 1;
			end
			if (!hsv_valid || !hsv_stall) begin
				if (hsv_gap > 0) begin
					hsv_gap <= hsv_gap - 1;
					hsv_valid <= 1'b0;
				end else if (pending_hsv.size() > 0) begin
					hsv <= pending_hsv.pop_front();
					hsv_valid <= 1'b1;
					hsv_gap <= draw_wait(items_sent);
				end else begin
					hsv_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result against the oldest expected color and
	// stalls for a drawn number of cycles after every item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_stall <= 1'b0;
			rgb_wait <= 0;
			results_seen <= 0;
		end else begin
			rgb_wait_next = (rgb_wait > 0) ? rgb_wait - 1 : 0;
			if (rgb_valid && !rgb_stall) begin
				if (expected_rgb.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result %0d: r=%0d g=%0d b=%0d",
							results_seen, rgb.red, rgb.green, rgb.blue);
				end else begin
					h2r_pkg::rgb_item_t want;
					want = expected_rgb.pop_front();
					if (rgb.red !== want.red || rgb.green !== want.green ||
							rgb.blue !== want.blue) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								results_seen, want.red, want.green, want.blue,
								rgb.red, rgb.green, rgb.blue);
					end
				end
				results_seen <= results_seen + 1;
				rgb_wait_next = draw_wait(results_seen);
			end
			rgb_wait <= rgb_wait_next;
			rgb_stall <= (rgb_wait_next > 0) || (hold_cycles != 0);
		end
	end

	// One long hold-off by the receiver so that the pipeline backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_used <= 1'b0;
		end else if (!hold_used && results_seen >= HOLD_AFTER) begin
			hold_cycles <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL hsv_to_rgb_core");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Primary and secondary colors at every sector start.
		add_hsv(0, 255, 255);
		add_hsv(960, 255, 255);
		add_hsv(1920, 255, 255);
		add_hsv(2880, 255, 255);
		add_hsv(3840, 255, 255);
		add_hsv(4800, 255, 255);
		// Last hue below a full turn, values right before sector edges and mid-sector hues.
		add_hsv(5759, 255, 255);
		add_hsv(959, 200, 180);
		add_hsv(1919, 200, 180);
		add_hsv(480, 255, 255);
		add_hsv(1440, 128, 255);
		// Grey with zero saturation, black with zero brightness.
		add_hsv(1234, 0, 200);
		add_hsv(3000, 255, 0);
		add_hsv(0, 0, 0);
		// Hues beyond a full turn fall into the last sector.
		add_hsv(5760, 255, 255);
		add_hsv(6000, 255, 255);
		add_hsv(7000, 128, 77);
		add_hsv(8191, 255, 255);
		add_hsv(7680, 100, 100);
		// Small and rounding-sensitive values.
		add_hsv(100, 1, 1);
		add_hsv(4321, 1, 255);
		add_hsv(2500, 254, 254);
		add_hsv(3333, 128, 128);
		add_hsv(8191, 0, 255);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_hsv(rand_hue(), rand_byte(), rand_byte());
		total_items = pending_hsv.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Every item has come back; a short drain catches any extra result.
		wait (results_seen >= total_items);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rgb.size() == 0)
			$display("PASS hsv_to_rgb_core");
		else
			$display("FAIL hsv_to_rgb_core");
		$finish;
	end

endmodule
